// ===== hdl/rsdm_pkg.sv =====
`default_nettype none
package rsdm_pkg;

    // field and register widths
    localparam int LS_W       = 32;
    localparam int SPU_W      = 16;
    localparam int DC_W       = 5;
    localparam int TC_W       = 6;
    localparam int RPG_W      = 9;
    localparam int UPD_W      = 24;
    localparam int GPA_W      = 9;
    localparam int ROT_W      = 2;
    localparam int COL_W      = 5;
    localparam int ROW_W      = 16;
    localparam int PHYS_W     = 32;
    localparam int STRIPE_W   = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MAX_COLUMNS_DEF = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPU = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RPG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GPA = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROT = 3'd6;

    // parity rotation codes
    localparam logic [ROT_W-1:0] ROT_NONE  = 2'd0;
    localparam logic [ROT_W-1:0] ROT_RIGHT = 2'd1;
    localparam logic [ROT_W-1:0] ROT_LEFT  = 2'd2;

    // remainders collected along the divider chain
    typedef struct packed {
        logic [SPU_W-1:0] sec;
        logic [DC_W-1:0]  col;
        logic [RPG_W-1:0] grow;
        logic [UPD_W-1:0] unit;
        logic [GPA_W-1:0] grp;
    } rsdm_side_t;

    // address parts after the multiply stages
    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [PHYS_W-1:0]   phys;
        logic [STRIPE_W-1:0] stripe;
        logic                oor;
    } rsdm_mid_t;

endpackage
`default_nettype wire

// ===== hdl/rsdm_div.sv =====
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module rsdm_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [SIDE_W-1:0] in_side,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quo,
    output logic [DEN_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);

    logic              vld_reg  [1:NUM_W];
    logic [DEN_W-1:0]  rem_reg  [1:NUM_W];
    logic [NUM_W-1:0]  nq_reg   [1:NUM_W];
    logic [SIDE_W-1:0] side_reg [1:NUM_W];

    for (genvar s = 1; s <= NUM_W; s++) begin : g_stage
        logic              prv_vld;
        logic [DEN_W-1:0]  prv_rem;
        logic [NUM_W-1:0]  prv_nq;
        logic [SIDE_W-1:0] prv_side;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W:0]    diff;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  nq_next;

        if (s == 1) begin : g_first
            assign prv_vld  = in_valid;
            assign prv_rem  = '0;
            assign prv_nq   = in_num;
            assign prv_side = in_side;
        end else begin : g_rest
            assign prv_vld  = vld_reg[s-1];
            assign prv_rem  = rem_reg[s-1];
            assign prv_nq   = nq_reg[s-1];
            assign prv_side = side_reg[s-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial    = {prv_rem, prv_nq[NUM_W-1]};
        assign ge       = trial >= {1'b0, den};
        assign diff     = trial - {1'b0, den};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign nq_next  = {prv_nq[NUM_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= prv_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                nq_reg[s]   <= nq_next;
                side_reg[s] <= prv_side;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = nq_reg[NUM_W];
    assign out_rem   = rem_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule
`default_nettype wire

// ===== hdl/rsdm_comb.sv =====
`default_nettype none
// two multiply stages: row, physical sector, stripe number
module rsdm_comb (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire rsdm_pkg::rsdm_side_t      in_side,
    input  wire logic [rsdm_pkg::LS_W-1:0] in_quo,
    input  wire logic [rsdm_pkg::SPU_W-1:0] spu,
    input  wire logic [rsdm_pkg::RPG_W-1:0] rpg,
    input  wire logic [rsdm_pkg::UPD_W-1:0] upd,
    output logic                           out_valid,
    output rsdm_pkg::rsdm_mid_t            out_mid
);
    import rsdm_pkg::*;

    logic              a_vld_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [31:0]       a_gu_reg;
    logic [PHYS_W-1:0] a_phys_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [RPG_W-1:0]  a_grow_reg;
    logic              a_oor_reg;
    logic              b_vld_reg;
    rsdm_mid_t         b_mid_reg;

    logic [17:0] row_prod;
    logic [17:0] row_sum;
    logic [32:0] gu_prod;
    logic [32:0] gu_sum;
    logic [39:0] ph_prod;
    logic [39:0] ph_sum;
    logic [40:0] st_prod;
    logic [40:0] st_sum;
    rsdm_mid_t   mid_next;

    // stage a: group row, group units plus unit, unit sectors plus sector
    assign row_prod = {9'b0, in_side.grp} * {9'b0, rpg};
    assign row_sum  = row_prod + {9'b0, in_side.grow};
    assign gu_prod  = {24'b0, in_side.grp} * {9'b0, upd};
    assign gu_sum   = gu_prod + {9'b0, in_side.unit};
    assign ph_prod  = {16'b0, in_side.unit} * {24'b0, spu};
    assign ph_sum   = ph_prod + {24'b0, in_side.sec};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_row_reg  <= row_sum[ROW_W-1:0];
            a_gu_reg   <= gu_sum[31:0];
            a_phys_reg <= ph_sum[PHYS_W-1:0];
            a_col_reg  <= in_side.col;
            a_grow_reg <= in_side.grow;
            a_oor_reg  <= (in_quo != '0);
        end
    end

    // stage b: stripe number at full width
    assign st_prod = {9'b0, a_gu_reg} * {32'b0, rpg};
    assign st_sum  = st_prod + {32'b0, a_grow_reg};

    always_comb begin
        mid_next.col    = a_col_reg;
        mid_next.row    = a_row_reg;
        mid_next.phys   = a_phys_reg;
        mid_next.stripe = st_sum[STRIPE_W-1:0];
        mid_next.oor    = a_oor_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_mid_reg <= mid_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_mid   = b_mid_reg;

endmodule
`default_nettype wire

// ===== hdl/rsdm_rot.sv =====
`default_nettype none
// parity rotation and the output register
module rsdm_rot #(
    parameter int CW = 6
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire rsdm_pkg::rsdm_mid_t         in_mid,
    input  wire logic [CW-1:0]               smod,
    input  wire logic [CW-1:0]               cm,
    input  wire logic [CW-1:0]               ncl,
    input  wire logic [rsdm_pkg::ROT_W-1:0]  mode,
    output logic                             out_valid,
    output logic [rsdm_pkg::COL_W-1:0]       data_col,
    output logic [rsdm_pkg::COL_W-1:0]       parity_col,
    output logic [rsdm_pkg::ROW_W-1:0]       disk_row,
    output logic [rsdm_pkg::PHYS_W-1:0]      phys_sector,
    output logic [31:0]                      stripe_number,
    output logic                             out_of_range
);
    import rsdm_pkg::*;

    logic              vld_reg;
    logic [COL_W-1:0]  dcol_reg;
    logic [COL_W-1:0]  pcol_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PHYS_W-1:0] phys_reg;
    logic [31:0]       stripe_reg;
    logic              oor_reg;

    logic [CW:0]      n_x;
    logic [CW:0]      rs;
    logic [CW:0]      ps;
    logic [CW:0]      r_d;
    logic [CW:0]      r_p;
    logic [CW:0]      l_d;
    logic [CW:0]      l_p;
    logic [CW:0]      dsel;
    logic [CW:0]      psel;
    logic [CW+5:0]    dext;
    logic [CW+5:0]    pext;
    logic [COL_W-1:0] dcol_next;
    logic [COL_W-1:0] pcol_next;

    // all operands are below the column count, so one subtract wraps
    assign n_x = {1'b0, ncl};
    assign rs  = {1'b0, cm} + {1'b0, smod};
    assign ps  = n_x - (CW+1)'(1) + {1'b0, smod};
    assign r_d = (rs >= n_x) ? rs - n_x : rs;
    assign r_p = (ps >= n_x) ? ps - n_x : ps;
    assign l_d = (cm >= smod) ? {1'b0, cm} - {1'b0, smod} : {1'b0, cm} + n_x - {1'b0, smod};
    assign l_p = n_x - (CW+1)'(1) - {1'b0, smod};

    always_comb begin
        dsel = '0;
        psel = '0;
        case (mode)
            ROT_RIGHT: begin
                dsel = r_d;
                psel = r_p;
            end
            ROT_LEFT: begin
                dsel = l_d;
                psel = l_p;
            end
            default: begin
                dsel = '0;
                psel = n_x - (CW+1)'(1);
            end
        endcase
        dext = (CW+6)'(dsel);
        pext = (CW+6)'(psel);
        if (mode == ROT_RIGHT || mode == ROT_LEFT) begin
            dcol_next = dext[COL_W-1:0];
        end else begin
            dcol_next = in_mid.col;
        end
        pcol_next = pext[COL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dcol_reg   <= dcol_next;
            pcol_reg   <= pcol_next;
            row_reg    <= in_mid.row;
            phys_reg   <= in_mid.phys;
            stripe_reg <= in_mid.stripe[31:0];
            oor_reg    <= in_mid.oor;
        end
    end

    assign out_valid     = vld_reg;
    assign data_col      = dcol_reg;
    assign parity_col    = pcol_reg;
    assign disk_row      = row_reg;
    assign phys_sector   = phys_reg;
    assign stripe_number = stripe_reg;
    assign out_of_range  = oor_reg;

endmodule
`default_nettype wire

// ===== hdl/raid_sector_to_disk_mapper.sv =====
`default_nettype none
// pipeline from item accept to result valid: five 32-stage dividers,
// two multiply stages, a 40-stage stripe modulo, a 5-stage column modulo, output stage
// throughput: one item per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low aresetn clears all valid bits and loads the
// geometry registers with 1, 1, 2, 1, 1, 1 and rotation none
module raid_sector_to_disk_mapper #(
    parameter int MAX_COLUMNS = rsdm_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [rsdm_pkg::LS_W-1:0]        s_logical_sector,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [rsdm_pkg::COL_W-1:0]            m_data_col,
    output logic [rsdm_pkg::COL_W-1:0]            m_parity_col,
    output logic [rsdm_pkg::ROW_W-1:0]            m_disk_row,
    output logic [rsdm_pkg::PHYS_W-1:0]           m_phys_sector,
    output logic [31:0]                           m_stripe_number,
    output logic                                  m_out_of_range,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rsdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rsdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rsdm_pkg::*;

    localparam int CW     = $clog2(MAX_COLUMNS + 1);
    localparam int SIDE_W = $bits(rsdm_side_t);
    localparam int MID_W  = $bits(rsdm_mid_t);

    logic [SPU_W-1:0] spu_reg;
    logic [DC_W-1:0]  dc_reg;
    logic [TC_W-1:0]  tc_reg;
    logic [RPG_W-1:0] rpg_reg;
    logic [UPD_W-1:0] upd_reg;
    logic [GPA_W-1:0] gpa_reg;
    logic [ROT_W-1:0] rot_reg;

    logic [SPU_W-1:0] spu_d;
    logic [DC_W-1:0]  dc_d;
    logic [RPG_W-1:0] rpg_d;
    logic [UPD_W-1:0] upd_d;
    logic [GPA_W-1:0] gpa_d;
    logic [CW-1:0]    ncl;

    logic en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spu_reg <= SPU_W'(1);
            dc_reg  <= DC_W'(1);
            tc_reg  <= TC_W'(2);
            rpg_reg <= RPG_W'(1);
            upd_reg <= UPD_W'(1);
            gpa_reg <= GPA_W'(1);
            rot_reg <= ROT_NONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SPU: spu_reg <= cfg_data[SPU_W-1:0];
                REG_DC:  dc_reg  <= cfg_data[DC_W-1:0];
                REG_TC:  tc_reg  <= cfg_data[TC_W-1:0];
                REG_RPG: rpg_reg <= cfg_data[RPG_W-1:0];
                REG_UPD: upd_reg <= cfg_data[UPD_W-1:0];
                REG_GPA: gpa_reg <= cfg_data[GPA_W-1:0];
                REG_ROT: rot_reg <= cfg_data[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // zero geometry acts as one, column count clamped
    assign spu_d = (spu_reg == '0) ? SPU_W'(1) : spu_reg;
    assign dc_d  = (dc_reg == '0) ? DC_W'(1) : dc_reg;
    assign rpg_d = (rpg_reg == '0) ? RPG_W'(1) : rpg_reg;
    assign upd_d = (upd_reg == '0) ? UPD_W'(1) : upd_reg;
    assign gpa_d = (gpa_reg == '0) ? GPA_W'(1) : gpa_reg;

    always_comb begin
        if (tc_reg == '0) begin
            ncl = CW'(1);
        end else if (32'(tc_reg) > MAX_COLUMNS) begin
            ncl = CW'(MAX_COLUMNS);
        end else begin
            ncl = CW'(tc_reg);
        end
    end

    // global advance: the pipeline moves unless a result is stuck at the output
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // divider chain
    logic                 d1_vld, d2_vld, d3_vld, d4_vld, d5_vld;
    logic [LS_W-1:0]      d1_q, d2_q, d3_q, d4_q, d5_q;
    logic [SPU_W-1:0]     d1_r;
    logic [DC_W-1:0]      d2_r;
    logic [RPG_W-1:0]     d3_r;
    logic [UPD_W-1:0]     d4_r;
    logic [GPA_W-1:0]     d5_r;
    rsdm_side_t           d1_s, d2_s, d3_s, d4_s, d5_s;
    rsdm_side_t           s2_in, s3_in, s4_in, s5_in, sc_in;

    always_comb begin
        s2_in      = d1_s;
        s2_in.sec  = d1_r;
        s3_in      = d2_s;
        s3_in.col  = d2_r;
        s4_in      = d3_s;
        s4_in.grow = d3_r;
        s5_in      = d4_s;
        s5_in.unit = d4_r;
        sc_in      = d5_s;
        sc_in.grp  = d5_r;
    end

    rsdm_div #(.NUM_W(LS_W), .DEN_W(SPU_W), .SIDE_W(SIDE_W)) u_div_spu (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_num(s_logical_sector), .in_side(SIDE_W'(0)),
        .den(spu_d), .out_valid(d1_vld), .out_quo(d1_q), .out_rem(d1_r), .out_side(d1_s)
    );

    rsdm_div #(.NUM_W(LS_W), .DEN_W(DC_W), .SIDE_W(SIDE_W)) u_div_dc (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d1_vld), .in_num(d1_q), .in_side(s2_in),
        .den(dc_d), .out_valid(d2_vld), .out_quo(d2_q), .out_rem(d2_r), .out_side(d2_s)
    );

    rsdm_div #(.NUM_W(LS_W), .DEN_W(RPG_W), .SIDE_W(SIDE_W)) u_div_rpg (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d2_vld), .in_num(d2_q), .in_side(s3_in),
        .den(rpg_d), .out_valid(d3_vld), .out_quo(d3_q), .out_rem(d3_r), .out_side(d3_s)
    );

    rsdm_div #(.NUM_W(LS_W), .DEN_W(UPD_W), .SIDE_W(SIDE_W)) u_div_upd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d3_vld), .in_num(d3_q), .in_side(s4_in),
        .den(upd_d), .out_valid(d4_vld), .out_quo(d4_q), .out_rem(d4_r), .out_side(d4_s)
    );

    rsdm_div #(.NUM_W(LS_W), .DEN_W(GPA_W), .SIDE_W(SIDE_W)) u_div_gpa (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d4_vld), .in_num(d4_q), .in_side(s5_in),
        .den(gpa_d), .out_valid(d5_vld), .out_quo(d5_q), .out_rem(d5_r), .out_side(d5_s)
    );

    // row, physical sector and stripe number
    logic      c_vld;
    rsdm_mid_t c_mid;

    rsdm_comb u_comb (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d5_vld), .in_side(sc_in), .in_quo(d5_q),
        .spu(spu_d), .rpg(rpg_d), .upd(upd_d),
        .out_valid(c_vld), .out_mid(c_mid)
    );

    // stripe number modulo column count
    logic                 m6_vld;
    logic [STRIPE_W-1:0]  m6_q;
    logic [CW-1:0]        m6_r;
    logic [MID_W-1:0]     m6_s;

    rsdm_div #(.NUM_W(STRIPE_W), .DEN_W(CW), .SIDE_W(MID_W)) u_mod_stripe (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c_vld), .in_num(c_mid.stripe), .in_side(c_mid),
        .den(ncl), .out_valid(m6_vld), .out_quo(m6_q), .out_rem(m6_r), .out_side(m6_s)
    );

    // data column modulo column count
    rsdm_mid_t            m6_mid;
    logic                 m7_vld;
    logic [COL_W-1:0]     m7_q;
    logic [CW-1:0]        m7_r;
    logic [MID_W+CW-1:0]  m7_s;
    rsdm_mid_t            r_mid;
    logic [CW-1:0]        r_smod;

    assign m6_mid = m6_s;

    rsdm_div #(.NUM_W(COL_W), .DEN_W(CW), .SIDE_W(MID_W + CW)) u_mod_col (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(m6_vld), .in_num(m6_mid.col), .in_side({m6_s, m6_r}),
        .den(ncl), .out_valid(m7_vld), .out_quo(m7_q), .out_rem(m7_r), .out_side(m7_s)
    );

    assign r_mid  = m7_s[MID_W+CW-1:CW];
    assign r_smod = m7_s[CW-1:0];

    rsdm_rot #(.CW(CW)) u_rot (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(m7_vld), .in_mid(r_mid), .smod(r_smod), .cm(m7_r),
        .ncl(ncl), .mode(rot_reg),
        .out_valid(m_valid), .data_col(m_data_col), .parity_col(m_parity_col),
        .disk_row(m_disk_row), .phys_sector(m_phys_sector),
        .stripe_number(m_stripe_number), .out_of_range(m_out_of_range)
    );

    // checks
    logic [CW+5:0] ncl_x;
    logic [CW+5:0] last_col_x;

    assign ncl_x      = (CW+6)'(ncl);
    assign last_col_x = ncl_x - (CW+6)'(1);

    a_accept_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_parity_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((CW+6)'(m_parity_col) < ncl_x || ncl_x > (CW+6)'(32)))
        else $error("parity column beyond column count");

    a_parity_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && rot_reg == ROT_NONE) |-> (m_parity_col == last_col_x[COL_W-1:0]))
        else $error("parity column not on last column without rotation");

    a_data_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (rot_reg == ROT_RIGHT || rot_reg == ROT_LEFT))
        |-> ((CW+6)'(m_data_col) < ncl_x || ncl_x > (CW+6)'(32)))
        else $error("rotated data column beyond column count");

endmodule
`default_nettype wire

// ===== tb/rsdm_checker.sv =====
`default_nettype none
module rsdm_checker
    import rsdm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [LS_W-1:0]       s_logical_sector,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [COL_W-1:0]      m_data_col,
    input  wire logic [COL_W-1:0]      m_parity_col,
    input  wire logic [ROW_W-1:0]      m_disk_row,
    input  wire logic [PHYS_W-1:0]     m_phys_sector,
    input  wire logic [31:0]           m_stripe_number,
    input  wire logic                  m_out_of_range,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct packed {
        logic [COL_W-1:0]  dcol;
        logic [COL_W-1:0]  pcol;
        logic [ROW_W-1:0]  row;
        logic [PHYS_W-1:0] phys;
        logic [31:0]       stripe;
        logic              oor;
    } disk_addr_t;

    // shadow geometry
    logic [SPU_W-1:0] geo_spu;
    logic [DC_W-1:0]  geo_dc;
    logic [TC_W-1:0]  geo_tc;
    logic [RPG_W-1:0] geo_rpg;
    logic [UPD_W-1:0] geo_upd;
    logic [GPA_W-1:0] geo_gpa;
    logic [ROT_W-1:0] geo_rot;

    disk_addr_t expected_addrs[$];

    function automatic disk_addr_t map_sector(input logic [LS_W-1:0] lsec);
        longint unsigned spu, dc, rpg, upd, gpa, n, q;
        longint unsigned sec, col, grow, unit, grp, stripe, smod, dcol, pcol;
        disk_addr_t r;
        spu = (geo_spu == 0) ? 1 : geo_spu;
        dc  = (geo_dc == 0) ? 1 : geo_dc;
        rpg = (geo_rpg == 0) ? 1 : geo_rpg;
        upd = (geo_upd == 0) ? 1 : geo_upd;
        gpa = (geo_gpa == 0) ? 1 : geo_gpa;
        n   = (geo_tc == 0) ? 1 : ((geo_tc > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : geo_tc);
        q = lsec;
        sec = q % spu;   q = q / spu;
        col = q % dc;    q = q / dc;
        grow = q % rpg;  q = q / rpg;
        unit = q % upd;  q = q / upd;
        grp = q % gpa;   q = q / gpa;
        stripe = (grp * upd + unit) * rpg + grow;
        smod = stripe % n;
        case (geo_rot)
            ROT_RIGHT: begin
                dcol = (col + smod) % n;
                pcol = (n - 1 + smod) % n;
            end
            ROT_LEFT: begin
                dcol = (col % n + n - smod) % n;
                pcol = (n - 1 + n - smod) % n;
            end
            default: begin
                dcol = col;
                pcol = n - 1;
            end
        endcase
        r.dcol   = dcol[COL_W-1:0];
        r.pcol   = pcol[COL_W-1:0];
        r.row    = 16'(grp * rpg + grow);
        r.phys   = 32'(unit * spu + sec);
        r.stripe = stripe[31:0];
        r.oor    = (q != 0);
        return r;
    endfunction

    // shadow register writes, predict on accept, compare on result
    always @(posedge aclk) begin
        disk_addr_t got, want;
        if (!aresetn) begin
            geo_spu <= 1;
            geo_dc  <= 1;
            geo_tc  <= 2;
            geo_rpg <= 1;
            geo_upd <= 1;
            geo_gpa <= 1;
            geo_rot <= ROT_NONE;
            expected_addrs.delete();
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPU: geo_spu <= cfg_data[SPU_W-1:0];
                    REG_DC:  geo_dc  <= cfg_data[DC_W-1:0];
                    REG_TC:  geo_tc  <= cfg_data[TC_W-1:0];
                    REG_RPG: geo_rpg <= cfg_data[RPG_W-1:0];
                    REG_UPD: geo_upd <= cfg_data[UPD_W-1:0];
                    REG_GPA: geo_gpa <= cfg_data[GPA_W-1:0];
                    REG_ROT: geo_rot <= cfg_data[ROT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_addrs.push_back(map_sector(s_logical_sector));
            if (m_valid && m_ready) begin
                got = '{m_data_col, m_parity_col, m_disk_row, m_phys_sector,
                        m_stripe_number, m_out_of_range};
                if (expected_addrs.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_addrs.pop_front();
                    if (got != want) begin
                        $display({"%0t: mismatch expected dcol=%0d pcol=%0d row=%0d",
                                  " phys=%h stripe=%h oor=%0d"},
                                 $time, want.dcol, want.pcol, want.row, want.phys,
                                 want.stripe, want.oor);
                        $display({"%0t:          actual dcol=%0d pcol=%0d row=%0d",
                                  " phys=%h stripe=%h oor=%0d"},
                                 $time, got.dcol, got.pcol, got.row, got.phys,
                                 got.stripe, got.oor);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_addrs.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
    import rsdm_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [LS_W-1:0] s_logical_sector = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [COL_W-1:0] m_data_col, m_parity_col;
    logic [ROW_W-1:0] m_disk_row;
    logic [PHYS_W-1:0] m_phys_sector;
    logic [31:0] m_stripe_number;
    logic m_out_of_range;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int fail_count, pending_count;
    bit sink_on = 0;

    raid_sector_to_disk_mapper dut (.*);

    rsdm_checker chk (.*);

    initial forever #5 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("raid_sector_to_disk_mapper verification failed");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays up across back to back writes, the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // valid drops only for a gap, so back to back items keep it high
    task automatic send_sector(input logic [LS_W-1:0] lsec);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_valid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_logical_sector <= lsec;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // wait for all results, then the pipeline depth before touching registers
    task automatic drain();
        s_valid <= 0;
        @(negedge aclk);
        while (pending_count != 0 || s_valid) @(negedge aclk);
        repeat (3) @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (230) @(negedge aclk);
    endtask

    task automatic load_geometry(input int spu, input int dc, input int tc, input int rpg,
                                 input int upd, input int gpa, input int rot);
        write_reg(REG_SPU, CFG_DATA_W'(spu));
        write_reg(REG_DC, CFG_DATA_W'(dc));
        write_reg(REG_TC, CFG_DATA_W'(tc));
        write_reg(REG_RPG, CFG_DATA_W'(rpg));
        write_reg(REG_UPD, CFG_DATA_W'(upd));
        write_reg(REG_GPA, CFG_DATA_W'(gpa));
        write_reg(REG_ROT, CFG_DATA_W'(rot));
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_sector();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 4095);
            2: return $urandom_range(0, 1 << 20);
            default: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(0, 255);
        endcase
    endfunction

    // result side backpressure
    always @(negedge aclk) begin
        if (!sink_on) m_ready <= 0;
        else if ($urandom_range(0, 99) < 8) m_ready <= 0;
        else if (!m_ready && $urandom_range(0, 99) < 70) m_ready <= 0;
        else m_ready <= 1;
    end

    initial begin
        int lo;
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        sink_on = 1;

        // reset geometry, field extremes
        send_sector(32'h0);
        send_sector(32'hFFFF_FFFF);
        send_sector(32'h1);
        drain();

        // zero divisors and zero column count, rotation code 3
        load_geometry(0, 0, 0, 0, 0, 0, 3);
        send_sector(32'h0);
        send_sector(32'h5);
        drain();

        // widest geometry, right symmetric
        load_geometry(65535, 31, 32, 256, 16777215, 256, ROT_RIGHT);
        send_sector(32'hFFFF_FFFF);
        send_sector(32'h8000_0000);
        send_sector(32'd65535);
        drain();

        // column count above the cap, left symmetric
        load_geometry(4, 5, 63, 3, 7, 2, ROT_LEFT);
        for (int i = 0; i < 10; i++) send_sector(i * 4 * 5 * 3);
        send_sector(32'hFFFF_FFFF);
        drain();

        // data columns beyond column count, no rotation
        load_geometry(1, 31, 4, 2, 3, 2, ROT_NONE);
        send_sector(32'd30);
        send_sector(32'd1000);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 4 == 3)
                load_geometry($urandom_range(0, 65535), $urandom_range(0, 31),
                              $urandom_range(0, 63), $urandom_range(0, 511),
                              $urandom, $urandom_range(0, 511), $urandom_range(0, 3));
            else
                load_geometry($urandom_range(1, 16), $urandom_range(1, 8),
                              $urandom_range(1, 12), $urandom_range(1, 8),
                              $urandom_range(1, 64), $urandom_range(1, 8),
                              $urandom_range(0, 2));
            lo = $urandom_range(0, 1);
            for (int i = 0; i < 150; i++) begin
                // occasional long result side stall, input idle meanwhile
                if (lo && $urandom_range(0, 9) == 0) begin
                    s_valid <= 0;
                    sink_on = 0;
                    repeat ($urandom_range(10, 40)) @(negedge aclk);
                    sink_on = 1;
                end
                send_sector(rand_sector());
            end
            sink_on = 1;
            drain();
        end

        if (fail_count == 0)
            $display("raid_sector_to_disk_mapper verification clean");
        else
            $display("raid_sector_to_disk_mapper verification failed");
        $finish;
    end

endmodule
`default_nettype wire
